### rtl/qrs_pkg.sv
// ----------------------------------------------------------------------------
// qrs_pkg
// shared constants and types for the quadratic root solver
// ----------------------------------------------------------------------------
`default_nettype none

package qrs_pkg;

   localparam int COEF_WIDTH_DEF = 16;
   localparam int ROOT_WIDTH_DEF = 32;

   // roots come out in q.16, coefficients are q.8, so -b is scaled by 2^15
   // and the square root is taken of d * 2^30
   localparam int FRAC_SHIFT = 15;
   localparam int RAD_SHIFT  = 2 * FRAC_SHIFT;

   localparam int STATUS_W = 2;
   localparam logic [STATUS_W-1:0] STATUS_NONE  = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_ONE   = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_TWO   = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_AZERO = 2'd3;

   // per-stage control that travels with every request
   typedef struct packed {
      logic valid;
      logic a_zero;
      logic d_neg;
      logic d_zero;
   } qrs_ctrl_type;

endpackage

`default_nettype wire

### rtl/qrs_sqrt_cell.sv
// ----------------------------------------------------------------------------
// qrs_sqrt_cell
// one result bit of the digit-by-digit square root, registered
// ----------------------------------------------------------------------------
`default_nettype none

module qrs_sqrt_cell #(
   parameter int CW = 16,
   parameter int SW = 33
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 en,
   input  wire qrs_pkg::qrs_ctrl_type ctrl_in,
   input  wire logic [CW-1:0]        a_in,
   input  wire logic [CW-1:0]        b_in,
   input  wire logic [2*SW-1:0]      rad_in,
   input  wire logic [SW:0]          rem_in,
   input  wire logic [SW-1:0]        root_in,
   output qrs_pkg::qrs_ctrl_type     ctrl_out,
   output logic      [CW-1:0]        a_out,
   output logic      [CW-1:0]        b_out,
   output logic      [2*SW-1:0]      rad_out,
   output logic      [SW:0]          rem_out,
   output logic      [SW-1:0]        root_out
);

   qrs_pkg::qrs_ctrl_type ctrl_ff;
   logic [CW-1:0]   a_ff, b_ff;
   logic [2*SW-1:0] rad_ff, rad_in_w;
   logic [SW:0]     rem_ff, rem_in_w;
   logic [SW-1:0]   root_ff, root_in_w;
   logic [SW+2:0]   r_sh, trial;
   logic            ge;

   always_comb begin
      r_sh      = {rem_in, rad_in[2*SW-1 -: 2]};
      trial     = {1'b0, root_in, 2'b01};
      ge        = (r_sh >= trial);
      rem_in_w  = ge ? (SW+1)'(r_sh - trial) : (SW+1)'(r_sh);
      root_in_w = {root_in[SW-2:0], ge};
      rad_in_w  = {rad_in[2*SW-3:0], 2'b00};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff <= '0;
      end else if (en) begin
         ctrl_ff <= ctrl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_ff    <= a_in;
         b_ff    <= b_in;
         rad_ff  <= rad_in_w;
         rem_ff  <= rem_in_w;
         root_ff <= root_in_w;
      end
   end

   assign ctrl_out = ctrl_ff;
   assign a_out    = a_ff;
   assign b_out    = b_ff;
   assign rad_out  = rad_ff;
   assign rem_out  = rem_ff;
   assign root_out = root_ff;

endmodule

`default_nettype wire

### rtl/qrs_div_cell.sv
// ----------------------------------------------------------------------------
// qrs_div_cell
// one quotient bit of restoring division for both root lanes, registered
// ----------------------------------------------------------------------------
`default_nettype none

module qrs_div_cell #(
   parameter int CW = 16,
   parameter int NW = 35
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  en,
   input  wire qrs_pkg::qrs_ctrl_type ctrl_in,
   input  wire logic [CW-1:0]         dvs_in,
   input  wire logic [1:0]            neg_in,
   input  wire logic [1:0][NW-1:0]    dvd_in,
   input  wire logic [1:0][CW-1:0]    rem_in,
   input  wire logic [1:0][NW-1:0]    quo_in,
   output qrs_pkg::qrs_ctrl_type      ctrl_out,
   output logic      [CW-1:0]         dvs_out,
   output logic      [1:0]            neg_out,
   output logic      [1:0][NW-1:0]    dvd_out,
   output logic      [1:0][CW-1:0]    rem_out,
   output logic      [1:0][NW-1:0]    quo_out
);

   qrs_pkg::qrs_ctrl_type ctrl_ff;
   logic [CW-1:0]         dvs_ff;
   logic [1:0]            neg_ff;
   logic [1:0][NW-1:0]    dvd_ff, dvd_in_w, quo_ff, quo_in_w;
   logic [1:0][CW-1:0]    rem_ff, rem_in_w;
   logic [CW:0]           r_sh;
   logic                  ge;

   always_comb begin
      for (int i = 0; i < 2; i++) begin
         r_sh        = {rem_in[i], dvd_in[i][NW-1]};
         ge          = (r_sh >= {1'b0, dvs_in});
         rem_in_w[i] = ge ? CW'(r_sh - {1'b0, dvs_in}) : CW'(r_sh);
         quo_in_w[i] = {quo_in[i][NW-2:0], ge};
         dvd_in_w[i] = {dvd_in[i][NW-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff <= '0;
      end else if (en) begin
         ctrl_ff <= ctrl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dvs_ff <= dvs_in;
         neg_ff <= neg_in;
         dvd_ff <= dvd_in_w;
         rem_ff <= rem_in_w;
         quo_ff <= quo_in_w;
      end
   end

   assign ctrl_out = ctrl_ff;
   assign dvs_out  = dvs_ff;
   assign neg_out  = neg_ff;
   assign dvd_out  = dvd_ff;
   assign rem_out  = rem_ff;
   assign quo_out  = quo_ff;

endmodule

`default_nettype wire

### rtl/quadratic_root_solver.sv
// ----------------------------------------------------------------------------
// quadratic_root_solver
// real roots of a*x^2 + b*x + c in q16.16 from q8.8 coefficients
// ----------------------------------------------------------------------------
// pipeline: stage 1, stage 2, SW cells of square root, the numerator stage,
//    NW cells of division and the output register, where SW = (2*COEF_WIDTH + 34) / 2
//    and NW = max(COEF_WIDTH + 16, SW + 1) + 1
// throughput: one request per cycle while the chain is not stalled, every cell hands on to its neighbor
// the whole chain stalls only while a result waits in the output register
// reset: synchronous, clears the valid bits of every stage; no payload reset
`default_nettype none

module quadratic_root_solver #(
   parameter int COEF_WIDTH = qrs_pkg::COEF_WIDTH_DEF,
   parameter int ROOT_WIDTH = qrs_pkg::ROOT_WIDTH_DEF
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_tvalid,
   output logic                                       req_tready,
   // coef_a, coef_b, coef_c from bit 0 up, zero padded to whole bytes
   input  wire logic [8*((3*COEF_WIDTH+7)/8)-1:0]     req_tdata,
   output logic                                       rsp_tvalid,
   input  wire logic                                  rsp_tready,
   // root_plus, root_minus from bit 0 up, zero padded to whole bytes
   output logic [8*((2*ROOT_WIDTH+7)/8)-1:0]          rsp_tdata,
   // status (2 bits), saturated from bit 0 up
   output logic [qrs_pkg::STATUS_W:0]                 rsp_tuser
);

   localparam int CW  = COEF_WIDTH;
   localparam int RW  = ROOT_WIDTH;
   localparam int DW  = 2 * CW + 3;                    // discriminant, signed
   localparam int SW  = (DW + qrs_pkg::RAD_SHIFT + 1) / 2;  // square root bits
   localparam int NBW = CW + qrs_pkg::FRAC_SHIFT + 1;
   localparam int NW  = ((NBW > SW + 1) ? NBW : SW + 1) + 1; // numerator, signed
   localparam int EW  = (NW + 1 > RW) ? NW + 1 : RW;  // clip compare width
   localparam int TDW = 8 * ((2 * RW + 7) / 8);
   localparam int PADW = 2 * SW - (DW - 1) - qrs_pkg::RAD_SHIFT;

   logic en;

   // ---------------------------------------------------------------- stage 1
   // products b*b and a*c
   logic                   s1_valid_ff;
   logic signed [CW-1:0]   s1_a_ff, s1_b_ff;
   logic signed [2*CW-1:0] s1_bb_ff, s1_ac_ff;
   logic signed [CW-1:0]   req_a, req_b, req_c;

   assign req_a = req_tdata[CW-1:0];
   assign req_b = req_tdata[2*CW-1:CW];
   assign req_c = req_tdata[3*CW-1:2*CW];

   // the pipe moves whenever the output register is free or being drained
   assign en         = !rsp_tvalid || rsp_tready;
   assign req_tready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (en) begin
         s1_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_a_ff  <= req_a;
         s1_b_ff  <= req_b;
         s1_bb_ff <= req_b * req_b;
         s1_ac_ff <= req_a * req_c;
      end
   end

   // ---------------------------------------------------------------- stage 2
   // discriminant, its sign and the scaled radicand
   logic signed [DW-1:0]  s2_d;
   qrs_pkg::qrs_ctrl_type s2_ctrl_ff, s2_ctrl_in;
   logic [CW-1:0]         s2_a_ff, s2_b_ff;
   logic [2*SW-1:0]       s2_rad_ff, s2_rad_in;

   always_comb begin
      s2_d              = DW'(s1_bb_ff) - (DW'(s1_ac_ff) <<< 2);
      s2_ctrl_in.valid  = s1_valid_ff;
      s2_ctrl_in.a_zero = (s1_a_ff == '0);
      s2_ctrl_in.d_neg  = s2_d[DW-1];
      s2_ctrl_in.d_zero = (s2_d == '0);
      // d shifted up by 2^30; meaningless when d is negative, masked later
      s2_rad_in = {{PADW{1'b0}}, s2_d[DW-2:0], {qrs_pkg::RAD_SHIFT{1'b0}}};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_ctrl_ff <= '0;
      end else if (en) begin
         s2_ctrl_ff <= s2_ctrl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s2_a_ff   <= s1_a_ff;
         s2_b_ff   <= s1_b_ff;
         s2_rad_ff <= s2_rad_in;
      end
   end

   // ------------------------------------------------------- square root chain
   qrs_pkg::qrs_ctrl_type sq_ctrl [0:SW];
   logic [CW-1:0]         sq_a    [0:SW];
   logic [CW-1:0]         sq_b    [0:SW];
   logic [2*SW-1:0]       sq_rad  [0:SW];
   logic [SW:0]           sq_rem  [0:SW];
   logic [SW-1:0]         sq_root [0:SW];

   assign sq_ctrl[0] = s2_ctrl_ff;
   assign sq_a[0]    = s2_a_ff;
   assign sq_b[0]    = s2_b_ff;
   assign sq_rad[0]  = s2_rad_ff;
   assign sq_rem[0]  = '0;
   assign sq_root[0] = '0;

   for (genvar g = 0; g < SW; g++) begin : g_sqrt
      qrs_sqrt_cell #(.CW(CW), .SW(SW)) u_cell (
         .clock    (clock),
         .reset    (reset),
         .en       (en),
         .ctrl_in  (sq_ctrl[g]),
         .a_in     (sq_a[g]),
         .b_in     (sq_b[g]),
         .rad_in   (sq_rad[g]),
         .rem_in   (sq_rem[g]),
         .root_in  (sq_root[g]),
         .ctrl_out (sq_ctrl[g+1]),
         .a_out    (sq_a[g+1]),
         .b_out    (sq_b[g+1]),
         .rad_out  (sq_rad[g+1]),
         .rem_out  (sq_rem[g+1]),
         .root_out (sq_root[g+1])
      );
   end

   // -------------------------------------------------------- numerator stage
   // n = -b*2^15 +/- s, split into magnitude and quotient sign
   logic signed [NW-1:0]  nm_nb, nm_s;
   logic signed [NW-1:0]  nm_n [2];
   qrs_pkg::qrs_ctrl_type nm_ctrl_ff;
   logic [CW-1:0]         nm_dvs_ff, nm_dvs_in;
   logic [1:0]            nm_neg_ff, nm_neg_in;
   logic [1:0][NW-1:0]    nm_mag_ff, nm_mag_in;
   logic signed [CW-1:0]  sq_a_last;

   assign sq_a_last = sq_a[SW];

   always_comb begin
      nm_nb = -(NW'($signed(sq_b[SW])) <<< qrs_pkg::FRAC_SHIFT);
      nm_s  = NW'(sq_root[SW]);
      nm_n[0] = nm_nb + nm_s;
      nm_n[1] = nm_nb - nm_s;
      for (int i = 0; i < 2; i++) begin
         nm_mag_in[i] = nm_n[i][NW-1] ? NW'(-nm_n[i]) : NW'(nm_n[i]);
         nm_neg_in[i] = nm_n[i][NW-1] ^ sq_a_last[CW-1];
      end
      nm_dvs_in = sq_a_last[CW-1] ? CW'(-sq_a_last) : CW'(sq_a_last);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         nm_ctrl_ff <= '0;
      end else if (en) begin
         nm_ctrl_ff <= sq_ctrl[SW];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         nm_dvs_ff <= nm_dvs_in;
         nm_neg_ff <= nm_neg_in;
         nm_mag_ff <= nm_mag_in;
      end
   end

   // ---------------------------------------------------------- divider chain
   qrs_pkg::qrs_ctrl_type dv_ctrl [0:NW];
   logic [CW-1:0]         dv_dvs  [0:NW];
   logic [1:0]            dv_neg  [0:NW];
   logic [1:0][NW-1:0]    dv_dvd  [0:NW];
   logic [1:0][CW-1:0]    dv_rem  [0:NW];
   logic [1:0][NW-1:0]    dv_quo  [0:NW];

   assign dv_ctrl[0] = nm_ctrl_ff;
   assign dv_dvs[0]  = nm_dvs_ff;
   assign dv_neg[0]  = nm_neg_ff;
   assign dv_dvd[0]  = nm_mag_ff;
   assign dv_rem[0]  = '0;
   assign dv_quo[0]  = '0;

   for (genvar g = 0; g < NW; g++) begin : g_div
      qrs_div_cell #(.CW(CW), .NW(NW)) u_cell (
         .clock    (clock),
         .reset    (reset),
         .en       (en),
         .ctrl_in  (dv_ctrl[g]),
         .dvs_in   (dv_dvs[g]),
         .neg_in   (dv_neg[g]),
         .dvd_in   (dv_dvd[g]),
         .rem_in   (dv_rem[g]),
         .quo_in   (dv_quo[g]),
         .ctrl_out (dv_ctrl[g+1]),
         .dvs_out  (dv_dvs[g+1]),
         .neg_out  (dv_neg[g+1]),
         .dvd_out  (dv_dvd[g+1]),
         .rem_out  (dv_rem[g+1]),
         .quo_out  (dv_quo[g+1])
      );
   end

   // ----------------------------------------------------- sign, clip, output
   localparam logic signed [EW-1:0] ROOT_HI = EW'((65'sd1 <<< (RW - 1)) - 65'sd1);
   localparam logic signed [EW-1:0] ROOT_LO = -ROOT_HI - EW'(1);

   qrs_pkg::qrs_ctrl_type       fin_ctrl;
   logic signed [EW-1:0]        fin_q [2];
   logic [1:0]                  fin_clip;
   logic [1:0][RW-1:0]          fin_root;
   logic [qrs_pkg::STATUS_W-1:0] fin_status;
   logic [1:0][RW-1:0]          out_root_in, out_root_ff;
   logic [qrs_pkg::STATUS_W-1:0] out_status_ff;
   logic                        out_sat_in, out_sat_ff, out_valid_ff;

   assign fin_ctrl = dv_ctrl[NW];

   always_comb begin
      for (int i = 0; i < 2; i++) begin
         // truncation toward zero: divide magnitudes, then apply the sign
         fin_q[i] = dv_neg[NW][i] ? -EW'({1'b0, dv_quo[NW][i]})
                                  :  EW'({1'b0, dv_quo[NW][i]});
         if (fin_q[i] > ROOT_HI) begin
            fin_root[i] = RW'(ROOT_HI);
            fin_clip[i] = 1'b1;
         end else if (fin_q[i] < ROOT_LO) begin
            fin_root[i] = RW'(ROOT_LO);
            fin_clip[i] = 1'b1;
         end else begin
            fin_root[i] = RW'(fin_q[i]);
            fin_clip[i] = 1'b0;
         end
      end

      if (fin_ctrl.a_zero) begin
         fin_status = qrs_pkg::STATUS_AZERO;
      end else if (fin_ctrl.d_neg) begin
         fin_status = qrs_pkg::STATUS_NONE;
      end else if (fin_ctrl.d_zero) begin
         fin_status = qrs_pkg::STATUS_ONE;
      end else begin
         fin_status = qrs_pkg::STATUS_TWO;
      end

      // a double root is the plus lane alone, with a zero square root
      case (fin_status)
         qrs_pkg::STATUS_TWO: begin
            out_root_in = fin_root;
            out_sat_in  = fin_clip[0] | fin_clip[1];
         end
         qrs_pkg::STATUS_ONE: begin
            out_root_in = {RW'(0), fin_root[0]};
            out_sat_in  = fin_clip[0];
         end
         default: begin
            out_root_in = '0;
            out_sat_in  = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (en) begin
         out_valid_ff <= fin_ctrl.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         out_root_ff   <= out_root_in;
         out_status_ff <= fin_status;
         out_sat_ff    <= out_sat_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = TDW'(out_root_ff);
   assign rsp_tuser  = {out_sat_ff, out_status_ff};

endmodule

`default_nettype wire

### rtl/qrs_checker.sv
// ----------------------------------------------------------------------------
// qrs_checker
// port-level checks on the result stream of the root solver
// ----------------------------------------------------------------------------
`default_nettype none

module qrs_checker #(
   parameter int COEF_WIDTH = qrs_pkg::COEF_WIDTH_DEF,
   parameter int ROOT_WIDTH = qrs_pkg::ROOT_WIDTH_DEF
) (
   input wire logic                                 clock,
   input wire logic                                 reset,
   input wire logic                                 req_tvalid,
   input wire logic                                 req_tready,
   input wire logic [8*((3*COEF_WIDTH+7)/8)-1:0]    req_tdata,
   input wire logic                                 rsp_tvalid,
   input wire logic                                 rsp_tready,
   input wire logic [8*((2*ROOT_WIDTH+7)/8)-1:0]    rsp_tdata,
   input wire logic [qrs_pkg::STATUS_W:0]           rsp_tuser
);

   localparam int RW = ROOT_WIDTH;

   logic [qrs_pkg::STATUS_W-1:0] st;
   assign st = rsp_tuser[qrs_pkg::STATUS_W-1:0];

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("rsp changed while stalled");

   // no roots and no clip flag without real roots
   a_no_roots: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (st == qrs_pkg::STATUS_NONE || st == qrs_pkg::STATUS_AZERO)
      |-> rsp_tdata[2*RW-1:0] == '0 && !rsp_tuser[qrs_pkg::STATUS_W])
      else $error("roots given without real roots");

   // a double root leaves the minus root empty
   a_one_root: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && st == qrs_pkg::STATUS_ONE |-> rsp_tdata[2*RW-1:RW] == '0)
      else $error("minus root set on double root");

   // nothing comes out right after reset, and the pipe accepts then
   a_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && req_tready)
      else $error("result or stall right after reset");

   // the input side never stalls while the output is free
   a_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("request stalled with free output");

endmodule

bind quadratic_root_solver qrs_checker #(
   .COEF_WIDTH (COEF_WIDTH),
   .ROOT_WIDTH (ROOT_WIDTH)
) u_qrs_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

`default_nettype wire

### tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// checks the quadratic root solver against its own root predictor with
// directed corner cases and random coefficient streams under flow control
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

module tb_top;

   localparam int CW = 16;
   localparam int RW = 32;
   localparam int DW = 8*((3*CW+7)/8);
   localparam int RDW = 8*((2*RW+7)/8);
   localparam int WATCHDOG_LIMIT = 20000;
   localparam int DRAIN_CYCLES = 200;

   typedef struct packed {
      logic [qrs_pkg::STATUS_W-1:0] status;
      logic [RW-1:0]       root_plus;
      logic [RW-1:0]       root_minus;
      logic                saturated;
   } roots_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [DW-1:0] req_tdata = '0;   // coef_a, coef_b, coef_c from bit 0 up
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RDW-1:0] rsp_tdata;       // root_plus, root_minus from bit 0 up
   logic [qrs_pkg::STATUS_W:0] rsp_tuser;    // status, saturated from bit 0 up

   roots_type expected_roots[$];
   int fail_count = 0;
   int sent_count = 0;
   int checked_count = 0;
   int idle_cycles = 0;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int status_seen[4] = '{0, 0, 0, 0};
   int sat_seen = 0;

   always #10 clock = ~clock;

   quadratic_root_solver dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser)
   );

   // bit-by-bit integer square root
   function automatic longint unsigned int_sqrt(input longint unsigned v);
      longint unsigned res;
      longint unsigned bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv >>= 2;
      while (bitv != 0) begin
         if (v >= res + bitv) begin
            v -= res + bitv;
            res = (res >> 1) + bitv;
         end else begin
            res >>= 1;
         end
         bitv >>= 2;
      end
      return res;
   endfunction

   // clip a root to the signed q16.16 range, flagging any clipping
   function automatic logic [RW-1:0] clip_root(input longint v, inout logic sat);
      longint hi;
      longint lo;
      hi = (64'sd1 <<< (RW-1)) - 1;
      lo = -hi - 1;
      if (v > hi) begin
         sat = 1'b1;
         return hi[RW-1:0];
      end
      if (v < lo) begin
         sat = 1'b1;
         return lo[RW-1:0];
      end
      return v[RW-1:0];
   endfunction

   function automatic roots_type solve_roots(input logic signed [CW-1:0] a,
                                             input logic signed [CW-1:0] b,
                                             input logic signed [CW-1:0] c);
      roots_type r;
      longint la, lb, lc, disc, nb, s;
      la = a; lb = b; lc = c;
      r = '0;
      if (la == 0) begin
         r.status = qrs_pkg::STATUS_AZERO;
      end else begin
         disc = lb*lb - 4*la*lc;
         nb = -lb * (64'sd1 <<< qrs_pkg::FRAC_SHIFT);
         if (disc < 0) begin
            r.status = qrs_pkg::STATUS_NONE;
         end else if (disc == 0) begin
            r.status = qrs_pkg::STATUS_ONE;
            r.root_plus = clip_root(nb / la, r.saturated);
         end else begin
            // sqrt of d in q.15, floored
            s = longint'(int_sqrt(longint'(disc) << qrs_pkg::RAD_SHIFT));
            r.status = qrs_pkg::STATUS_TWO;
            r.root_plus = clip_root((nb + s) / la, r.saturated);
            r.root_minus = clip_root((nb - s) / la, r.saturated);
         end
      end
      return r;
   endfunction

   // send one request, with random idle cycles before it
   task automatic send_coefs(input logic [CW-1:0] a, input logic [CW-1:0] b,
                             input logic [CW-1:0] c);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {c, b, a};
      expected_roots.push_back(solve_roots(a, b, c));
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sent_count++;
   endtask

   task automatic end_burst();
      req_tvalid <= 1'b0;
   endtask

   task automatic wait_drained();
      end_burst();
      while (expected_roots.size() != 0) @(posedge clock);
   endtask

   // receiver stall pattern
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // result checker
   always @(posedge clock) begin
      roots_type want;
      roots_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.status = rsp_tuser[qrs_pkg::STATUS_W-1:0];
         got.saturated = rsp_tuser[qrs_pkg::STATUS_W];
         got.root_plus = rsp_tdata[RW-1:0];
         got.root_minus = rsp_tdata[2*RW-1:RW];
         checked_count++;
         if (expected_roots.size() == 0) begin
            $display("%0t: unexpected result status %0d", $time, got.status);
            fail_count++;
         end else begin
            want = expected_roots.pop_front();
            status_seen[got.status]++;
            if (got.saturated) sat_seen++;
            if (got !== want) begin
               $display("%0t: mismatch expected st=%0d rp=%h rm=%h sat=%b",
                        $time, want.status, want.root_plus, want.root_minus,
                        want.saturated);
               $display("%0t:          actual   st=%0d rp=%h rm=%h sat=%b",
                        $time, got.status, got.root_plus, got.root_minus,
                        got.saturated);
               fail_count++;
            end
         end
      end
   end

   // watchdog: cycles with no handshake on either side
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog expired, %0d results outstanding", expected_roots.size());
         $display("Simulation FAILED");
         $finish;
      end
   end

   // corners: a zero, field extremes, single and double roots, saturation
   task automatic test_directed();
      send_coefs(16'h0000, 16'h1234, 16'h5678);   // a zero
      send_coefs(16'h0000, 16'h0000, 16'h0000);
      send_coefs(16'h0100, 16'h0000, 16'h0100);   // x^2+1: no root
      send_coefs(16'h0100, 16'hfe00, 16'h0100);   // (x-1)^2: one root
      send_coefs(16'h0100, 16'h0000, 16'hff00);   // x^2-1: two roots
      send_coefs(16'h8000, 16'h8000, 16'h8000);
      send_coefs(16'h7fff, 16'h7fff, 16'h7fff);
      send_coefs(16'h7fff, 16'h8000, 16'h8000);
      send_coefs(16'h8000, 16'h7fff, 16'h7fff);
      send_coefs(16'h0001, 16'h7fff, 16'h0000);   // huge root, still in range
      send_coefs(16'h0001, 16'h8000, 16'h0000);
      send_coefs(16'hffff, 16'h7fff, 16'h0000);
      send_coefs(16'h0001, 16'h0000, 16'h8000);   // big two roots
      send_coefs(16'hffff, 16'h0000, 16'h7fff);
      send_coefs(16'h0001, 16'h0002, 16'h0001);   // one root, tiny a
      send_coefs(16'h0001, 16'h8000, 16'h4000);   // two roots, b min
      send_coefs(16'hffff, 16'hffff, 16'hffff);
      send_coefs(16'h0001, 16'h0001, 16'h0001);
      send_coefs(16'h5555, 16'haaaa, 16'h5555);
      send_coefs(16'haaaa, 16'h5555, 16'haaaa);
      wait_drained();
   endtask

   // random coefficients, mixing wide values and small ones that land on edges
   task automatic test_random(input int count);
      logic [CW-1:0] a, b, c;
      int k, sel;
      longint la, lb;
      for (k = 0; k < count; k++) begin
         sel = $urandom_range(9);
         a = CW'($urandom); b = CW'($urandom); c = CW'($urandom);
         if (sel == 0) a = '0;
         else if (sel < 3) begin
            // perfect square: a*(x-r)^2 gives zero discriminant
            a = CW'($urandom_range(1, 30));
            if ($urandom_range(1) != 0) a = -a;
            la = longint'($signed(a));
            lb = longint'($urandom_range(0, 60)) - 30;
            b = CW'(2 * la * lb);
            c = CW'(la * lb * lb);
         end else if (sel < 5) begin
            a = CW'(int'($urandom_range(0, 511)) - 256);
            if (a == '0) a = CW'(1);
            b = CW'(int'($urandom_range(0, 511)) - 256);
            c = CW'(int'($urandom_range(0, 511)) - 256);
         end
         send_coefs(a, b, c);
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      send_idle_pct = 0;  recv_stall_pct = 0;  test_random(340);
      send_idle_pct = 66; recv_stall_pct = 0;  test_random(330);
      wait_drained();   // sender holds off until every result is back
      send_idle_pct = 0;  recv_stall_pct = 66; test_random(330);
      send_idle_pct = 18; recv_stall_pct = 18; test_random(330);
      wait_drained();
      recv_stall_pct = 0;
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("sent %0d coefficient sets, checked %0d results", sent_count, checked_count);
      $display("status none/one/two/azero = %0d/%0d/%0d/%0d, saturated %0d",
               status_seen[0], status_seen[1], status_seen[2], status_seen[3], sat_seen);
      if (fail_count == 0 && expected_roots.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

`default_nettype wire
